// ===== rtl/rte_pkg.sv =====
// ----------------------------------------------------------------------------
// rte_pkg
// Shared types and constants for the relocation table encoder.
// ----------------------------------------------------------------------------
package rte_pkg;

  localparam int DIST_BITS   = 31;
  localparam int QDEPTH      = 4;
  localparam int QPTR_BITS   = 2;
  localparam int RECIP_SHIFT = 38;

  // floor(2^38 / 127)
  localparam logic [31:0] RECIP_M = 32'd2164392968;
  localparam logic [7:0]  GAP_HALF = 8'd127;

  localparam logic        OP_TAG = 1'b0;
  localparam logic        OP_END = 1'b1;

  localparam logic [15:0] TAG_NONE_A = 16'd0;
  localparam logic [15:0] TAG_NONE_B = 16'd7;
  localparam logic [15:0] TAG_PAIR   = 16'd5;
  localparam logic [15:0] PAIR_NONE  = 16'd0;
  localparam logic [15:0] PAIR_MAX   = 16'd3;

  typedef enum logic [2:0] {
    KIND_FIRST    = 3'd0,
    KIND_GAP      = 3'd1,
    KIND_END      = 3'd2,
    KIND_BAD_TAG  = 3'd3,
    KIND_BAD_PAIR = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [DIST_BITS-1:0] wdist;
  } rec_t;

endpackage

// ===== rtl/relocation_table_encoder.sv =====
// ----------------------------------------------------------------------------
// relocation_table_encoder
// Turns a stream of relocation tag words into compact relocation table
// entries: first offset, gap entries, terminator and error words.
// ----------------------------------------------------------------------------
// Throughput: one tag word per cycle while the 4-entry record queue is not
//   full; the queue feeds the reciprocal-multiply divide pipeline (one
//   COUNT_BITS x 32 multiply stage), which stalls while a held result waits on out_ready.
// Reset: synchronous rst_n clears word counter, pair state, queue and all
//   valid flags; the block is ready as soon as reset is released.
module relocation_table_encoder #(
  parameter int COUNT_BITS = 31
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] tag_word
  input  logic        in_tuser,   // [0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [31:0] first_offset, [56:32] run_count,
                                  // [64:57] final_byte, [71:65] zero
  output logic [2:0]  out_tuser   // [2:0] kind
);

  logic           q_push, q_pop, q_full, q_empty;
  rte_pkg::rec_t  q_wdata, q_rdata;
  rte_pkg::kind_t o_kind;
  logic [31:0]    o_first;
  logic [24:0]    o_run;
  logic [7:0]     o_fin;

  rte_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .op       (in_tuser),
    .tag      (in_tdata),
    .q_full   (q_full),
    .push     (q_push),
    .rec      (q_wdata)
  );

  rte_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  rte_back #(.COUNT_BITS(COUNT_BITS)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_rdata          (q_rdata),
    .q_pop            (q_pop),
    .out_valid        (out_tvalid),
    .out_ready        (out_tready),
    .out_kind         (o_kind),
    .out_first_offset (o_first),
    .out_run_count    (o_run),
    .out_final_byte   (o_fin)
  );

  assign out_tuser = o_kind;
  assign out_tdata = {7'b0, o_fin, o_run, o_first};

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("record queue overflow");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("record queue underflow");

  a_gap_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == rte_pkg::KIND_GAP) |->
      (out_tdata[57] == 1'b0 && out_tdata[64:57] != 8'd0 && out_tdata[31:0] == 32'd0))
    else $error("gap entry with bad final byte");

  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == rte_pkg::KIND_END) |-> (out_tdata == 72'd0))
    else $error("terminator with nonzero payload");

endmodule

// ===== rtl/rte_front.sv =====
// ----------------------------------------------------------------------------
// rte_front
// Tag classifier: tracks word distance and pair state, emits one record per
// word that produces a result.
// ----------------------------------------------------------------------------
module rte_front #(
  parameter int COUNT_BITS = 31
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               op,
  input  logic [15:0]        tag,
  input  logic               q_full,
  output logic               push,
  output rte_pkg::rec_t      rec
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic [COUNT_BITS-1:0] pd_r, pd_nxt;
  logic                  first_r, first_nxt;
  logic                  pair_r, pair_nxt;
  logic                  acc, has;

  assign in_ready = !q_full;
  assign acc      = in_valid && !q_full;
  assign cnt_inc  = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 1'b1;
  assign push     = acc && has;

  always_comb begin
    cnt_nxt   = cnt_inc;
    pd_nxt    = pd_r;
    first_nxt = first_r;
    pair_nxt  = pair_r;
    has       = 1'b0;
    rec.kind  = rte_pkg::KIND_END;
    rec.wdist = '0;
    if (op == rte_pkg::OP_END) begin
      cnt_nxt   = '0;
      pd_nxt    = '0;
      first_nxt = 1'b1;
      pair_nxt  = 1'b0;
      has       = 1'b1;
    end else if (pair_r) begin
      pair_nxt = 1'b0;
      if (tag == rte_pkg::PAIR_NONE) begin
        cnt_nxt = cnt_inc;
      end else if (tag <= rte_pkg::PAIR_MAX) begin
        has       = 1'b1;
        rec.kind  = first_r ? rte_pkg::KIND_FIRST : rte_pkg::KIND_GAP;
        rec.wdist = rte_pkg::DIST_BITS'(pd_r);
        first_nxt = 1'b0;
        cnt_nxt   = COUNT_BITS'(2);
      end else begin
        has      = 1'b1;
        rec.kind = rte_pkg::KIND_BAD_PAIR;
      end
    end else begin
      unique case (tag) inside
        rte_pkg::TAG_NONE_A, rte_pkg::TAG_NONE_B: begin
          has = 1'b0;
        end
        rte_pkg::TAG_PAIR: begin
          pair_nxt = 1'b1;
          pd_nxt   = cnt_r;
        end
        default: begin
          has      = 1'b1;
          rec.kind = rte_pkg::KIND_BAD_TAG;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      pd_r    <= '0;
      first_r <= 1'b1;
      pair_r  <= 1'b0;
    end else if (acc) begin
      cnt_r   <= cnt_nxt;
      pd_r    <= pd_nxt;
      first_r <= first_nxt;
      pair_r  <= pair_nxt;
    end
  end

endmodule

// ===== rtl/rte_queue.sv =====
// ----------------------------------------------------------------------------
// rte_queue
// Small record FIFO between classifier and encoder pipeline.
// ----------------------------------------------------------------------------
module rte_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rte_pkg::rec_t wdata,
  input  logic          pop,
  output rte_pkg::rec_t rdata,
  output logic          full,
  output logic          empty
);

  rte_pkg::rec_t                 mem [rte_pkg::QDEPTH];
  logic [rte_pkg::QPTR_BITS-1:0] wr_r, rd_r;
  logic [rte_pkg::QPTR_BITS:0]   cnt_r;

  assign full  = (cnt_r == (rte_pkg::QPTR_BITS+1)'(rte_pkg::QDEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/rte_back.sv =====
// ----------------------------------------------------------------------------
// rte_back
// Encoder pipeline: splits a word distance into 254-byte runs and a final
// byte by reciprocal multiply, then holds the result word for output.
// ----------------------------------------------------------------------------
module rte_back #(
  parameter int COUNT_BITS = 31
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  rte_pkg::rec_t q_rdata,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output rte_pkg::kind_t out_kind,
  output logic [31:0]   out_first_offset,
  output logic [24:0]   out_run_count,
  output logic [7:0]    out_final_byte
);

  localparam int QW = COUNT_BITS - 6;
  localparam int PW = COUNT_BITS + 32;

  logic adv;
  logic v1_r, v2_r, v3_r, vo_r;

  rte_pkg::kind_t        k1_r, k2_r, k3_r;
  logic [COUNT_BITS-1:0] d1_r, d2_r, d3_r;
  logic [COUNT_BITS-1:0] y1_r, y2_r;
  logic                  z1_r, z2_r, z3_r;
  logic [PW-1:0]         prod2_r;
  logic [QW-1:0]         q3_r;
  logic [7:0]            r3_r;

  logic [COUNT_BITS-1:0] dist_in, y_in;
  logic [QW-1:0]         q0;
  logic [COUNT_BITS:0]   m127, r_full;
  logic                  inc;
  logic [QW-1:0]         q_fin;
  logic [6:0]            rem7;
  logic [7:0]            fin;

  assign adv       = !vo_r || out_ready;
  assign q_pop     = adv && !q_empty;
  assign out_valid = vo_r;

  assign dist_in = q_rdata.wdist[COUNT_BITS-1:0];
  assign y_in    = (dist_in == '0) ? '0 : dist_in - 1'b1;

  assign q0     = prod2_r[PW-1:rte_pkg::RECIP_SHIFT];
  assign m127   = {q0, 7'b0} - {7'b0, q0};
  assign r_full = {1'b0, y2_r} - m127;

  assign inc   = (r3_r >= rte_pkg::GAP_HALF);
  assign q_fin = q3_r + QW'(inc);
  assign rem7  = inc ? 7'(r3_r - rte_pkg::GAP_HALF) : r3_r[6:0];
  assign fin   = z3_r ? 8'd0 : {rem7 + 7'd1, 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (adv) begin
      v1_r <= q_pop;
      v2_r <= v1_r;
      v3_r <= v2_r;
      vo_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k1_r    <= q_rdata.kind;
      d1_r    <= dist_in;
      y1_r    <= y_in;
      z1_r    <= (dist_in == '0);
      k2_r    <= k1_r;
      d2_r    <= d1_r;
      y2_r    <= y1_r;
      z2_r    <= z1_r;
      prod2_r <= PW'(y1_r) * PW'(rte_pkg::RECIP_M);
      k3_r    <= k2_r;
      d3_r    <= d2_r;
      z3_r    <= z2_r;
      q3_r    <= q0;
      r3_r    <= r_full[7:0];
      if (v3_r) begin
        out_kind         <= k3_r;
        out_first_offset <= '0;
        out_run_count    <= '0;
        out_final_byte   <= '0;
        unique case (k3_r)
          rte_pkg::KIND_FIRST: begin
            out_first_offset <= 32'({d3_r, 1'b0});
          end
          rte_pkg::KIND_GAP: begin
            out_run_count  <= z3_r ? 25'd0 : 25'(q_fin);
            out_final_byte <= fin;
          end
          default: begin
            out_final_byte <= '0;
          end
        endcase
      end
    end
  end

endmodule
